// ===== design/scp_pkg.sv =====
// Shared types, widths and register codes for the skin color plausibility block.
package scp_pkg;

  localparam int CHAN_W     = 8;
  localparam int PCT_W      = 7;
  localparam int CNT_W      = 17;
  localparam int ABN_W      = 19;
  localparam int HIT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Saturation points of the image counters
  localparam logic [CNT_W-1:0] PIX_CAP = 17'd65536;
  localparam logic [ABN_W-1:0] ABN_CAP = 19'd327680;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED_MARGIN     = 3'd0,
    CFG_RATIO_PERCENT  = 3'd1,
    CFG_SATURATE_LEVEL = 3'd2,
    CFG_SPREAD_LIMIT   = 3'd3,
    CFG_BLUE_FLOOR     = 3'd4,
    CFG_BRIGHT_FLOOR   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_margin;
    logic [PCT_W-1:0]  ratio_percent;
    logic [CHAN_W-1:0] saturate_level;
    logic [CHAN_W-1:0] spread_limit;
    logic [CHAN_W-1:0] blue_floor;
    logic [CHAN_W-1:0] bright_floor;
  } cfg_t;

  // Per-pixel classification handed to the accumulator
  typedef struct packed {
    logic             reddish;
    logic             bright;
    logic [HIT_W-1:0] hits;
    logic             last;
  } flags_t;

  // Image totals captured on the last pixel
  typedef struct packed {
    logic [CNT_W-1:0] pixels;
    logic [CNT_W-1:0] reddish;
    logic [ABN_W-1:0] abnormal;
    logic [CNT_W-1:0] bright;
  } totals_t;

endpackage

// ===== design/scp_ifs.sv =====
// Valid/ready channel interfaces for pixel requests and verdict results.
interface scp_pix_if;
  logic                       valid;
  logic                       ready;
  logic [scp_pkg::CHAN_W-1:0] blue;
  logic [scp_pkg::CHAN_W-1:0] green;
  logic [scp_pkg::CHAN_W-1:0] red;
  logic                       last_pixel;

  modport source (output valid, blue, green, red, last_pixel, input ready);
  modport sink   (input valid, blue, green, red, last_pixel, output ready);
endinterface

interface scp_res_if;
  logic                      valid;
  logic                      ready;
  logic                      is_face;
  logic [scp_pkg::ABN_W-1:0] abnormal_total;
  logic [scp_pkg::CNT_W-1:0] bright_total;
  logic [scp_pkg::CNT_W-1:0] reddish_total;

  modport source (output valid, is_face, abnormal_total, bright_total, reddish_total,
                  input ready);
  modport sink   (input valid, is_face, abnormal_total, bright_total, reddish_total,
                  output ready);
endinterface

// ===== design/skin_color_plausibility.sv =====
// Top level: skin color plausibility check over a streamed BGR image.
// Throughput: one pixel request per cycle, sustained while results are taken.
// Path: a last pixel's verdict passes the input register at acceptance, then the
// classification register, the totals snapshot and the output register.
// Input stalls only when a verdict meets a full output register and a full snapshot.
// Reset (synchronous, rst_n low): counters and valid flags clear, config registers take default values.
module skin_color_plausibility (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [scp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  scp_pix_if.sink                        in_chan,
  scp_res_if.source                      out_chan
);
  import scp_pkg::*;

  cfg_t    cfg;
  flags_t  flg;
  totals_t snap;
  logic    flg_valid;
  logic    acc_ready;
  logic    snap_valid;
  logic    snap_ready;

  scp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  scp_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_chan   (in_chan),
    .acc_ready (acc_ready),
    .flg_valid (flg_valid),
    .flg       (flg)
  );

  scp_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .flg_valid  (flg_valid),
    .flg        (flg),
    .acc_ready  (acc_ready),
    .snap_ready (snap_ready),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  scp_verdict u_verdict (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_chan   (out_chan)
  );

  // Input backpressure only ever comes from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready))
    else $error("input stalled without result backpressure");

  // A face needs at least one reddish pixel
  a_face_reddish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.is_face) |-> (out_chan.reddish_total != '0))
    else $error("face verdict with no reddish pixels");

  // A face keeps abnormal and bright counts within half the largest image
  a_face_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.is_face) |->
      ((out_chan.abnormal_total <= 19'd32768) && (out_chan.bright_total <= 17'd32768)))
    else $error("face verdict with excessive abnormal or bright counts");

endmodule

// ===== design/scp_cfg_regs.sv =====
// Configuration register file with write-only access.
module scp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [scp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output scp_pkg::cfg_t                 cfg
);
  import scp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Index decode; unknown indexes leave everything unchanged
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_RED_MARGIN:     cfg_nxt.red_margin     = cfg_wdata;
        CFG_RATIO_PERCENT:  cfg_nxt.ratio_percent  = cfg_wdata[PCT_W-1:0];
        CFG_SATURATE_LEVEL: cfg_nxt.saturate_level = cfg_wdata;
        CFG_SPREAD_LIMIT:   cfg_nxt.spread_limit   = cfg_wdata;
        CFG_BLUE_FLOOR:     cfg_nxt.blue_floor     = cfg_wdata;
        CFG_BRIGHT_FLOOR:   cfg_nxt.bright_floor   = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_margin     <= 8'd60;
      cfg_r.ratio_percent  <= 7'd15;
      cfg_r.saturate_level <= 8'd240;
      cfg_r.spread_limit   <= 8'd5;
      cfg_r.blue_floor     <= 8'd150;
      cfg_r.bright_floor   <= 8'd200;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/scp_classify.sv =====
// Pixel input register, per-pixel color tests and classification register.
module scp_classify (
  input  logic            clk,
  input  logic            rst_n,
  input  scp_pkg::cfg_t   cfg,
  scp_pix_if.sink         in_chan,
  input  logic            acc_ready,
  output logic            flg_valid,
  output scp_pkg::flags_t flg
);
  import scp_pkg::*;

  // Stage 1: captured pixel
  logic              v1_r;
  logic [CHAN_W-1:0] b_r, g_r, r_r;
  logic              last_r;
  // Stage 2: classification
  logic              v2_r;
  flags_t            flg_r;
  flags_t            flg_nxt;

  logic s2_ready;
  logic s1_move;

  assign s2_ready       = !v2_r || acc_ready;
  assign s1_move        = v1_r && s2_ready;
  assign in_chan.ready  = !v1_r || s2_ready;

  // Scale a channel difference by one hundred (shift-add)
  function automatic logic signed [16:0] times100(input logic signed [9:0] d);
    logic signed [16:0] dx;
    dx = 17'(d);
    return (dx <<< 6) + (dx <<< 5) + (dx <<< 2);
  endfunction

  logic signed [9:0]  d_rg, d_rb, d_gr, d_br;
  logic signed [16:0] d_rg100, d_rb100, d_gr100, d_br100;
  logic [14:0]        r_pct, g_pct, b_pct;
  logic [CHAN_W-1:0]  lo, hi;
  logic               t_strong, t_redblue, t_green, t_sat, t_blue;

  // Color tests: d > floor(c*p/100) is checked as 100*d > c*p
  always_comb begin
    d_rg = $signed({2'b00, r_r}) - $signed({2'b00, g_r});
    d_rb = $signed({2'b00, r_r}) - $signed({2'b00, b_r});
    d_gr = -d_rg;
    d_br = -d_rb;
    d_rg100 = times100(d_rg);
    d_rb100 = times100(d_rb);
    d_gr100 = times100(d_gr);
    d_br100 = times100(d_br);
    r_pct = 15'(r_r) * 15'(cfg.ratio_percent);
    g_pct = 15'(g_r) * 15'(cfg.ratio_percent);
    b_pct = 15'(b_r) * 15'(cfg.ratio_percent);

    t_strong  = (d_rg > $signed({2'b00, cfg.red_margin}))
             && (d_rb > $signed({2'b00, cfg.red_margin}));
    t_redblue = (d_rg100 > $signed({2'b00, r_pct}))
             && (d_rb100 > $signed({2'b00, r_pct})) && (b_r > g_r);
    t_green   = d_gr100 > $signed({2'b00, g_pct});
    t_sat     = (r_r > cfg.saturate_level) && (g_r > cfg.saturate_level)
             && (b_r > cfg.saturate_level);
    t_blue    = (d_br100 > $signed({2'b00, b_pct})) && (b_r > cfg.blue_floor);

    // Channel extremes for the grey test
    lo = (r_r < g_r) ? r_r : g_r;
    lo = (lo < b_r) ? lo : b_r;
    hi = (r_r > g_r) ? r_r : g_r;
    hi = (hi > b_r) ? hi : b_r;

    flg_nxt.reddish = r_r > g_r;
    flg_nxt.bright  = ((hi - lo) < cfg.spread_limit) && (lo > cfg.bright_floor);
    flg_nxt.hits    = HIT_W'(t_strong) + HIT_W'(t_redblue) + HIT_W'(t_green)
                    + HIT_W'(t_sat) + HIT_W'(t_blue);
    flg_nxt.last    = last_r;
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_chan.ready) v1_r <= in_chan.valid;
      if (s2_ready)      v2_r <= v1_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      b_r    <= in_chan.blue;
      g_r    <= in_chan.green;
      r_r    <= in_chan.red;
      last_r <= in_chan.last_pixel;
    end
    if (s1_move) flg_r <= flg_nxt;
  end

  assign flg_valid = v2_r;
  assign flg       = flg_r;

endmodule

// ===== design/scp_accum.sv =====
// Saturating image counters and last-pixel snapshot of the totals.
module scp_accum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             flg_valid,
  input  scp_pkg::flags_t  flg,
  output logic             acc_ready,
  input  logic             snap_ready,
  output logic             snap_valid,
  output scp_pkg::totals_t snap
);
  import scp_pkg::*;

  logic [CNT_W-1:0] pix_r, red_r, bri_r;
  logic [ABN_W-1:0] abn_r;
  logic             v3_r;
  totals_t          snap_r;
  totals_t          upd;

  logic             take;
  logic [CNT_W:0]   pix_sum, red_sum, bri_sum;
  logic [ABN_W:0]   abn_sum;

  // A last pixel needs the snapshot slot; other pixels are always absorbed
  assign acc_ready = !flg.last || !v3_r || snap_ready;
  assign take      = flg_valid && acc_ready;

  // Saturating increments
  always_comb begin
    pix_sum = {1'b0, pix_r} + (CNT_W+1)'(1);
    red_sum = {1'b0, red_r} + (CNT_W+1)'(flg.reddish);
    bri_sum = {1'b0, bri_r} + (CNT_W+1)'(flg.bright);
    abn_sum = {1'b0, abn_r} + (ABN_W+1)'(flg.hits);
    upd.pixels   = (pix_sum > {1'b0, PIX_CAP}) ? PIX_CAP : pix_sum[CNT_W-1:0];
    upd.reddish  = (red_sum > {1'b0, PIX_CAP}) ? PIX_CAP : red_sum[CNT_W-1:0];
    upd.bright   = (bri_sum > {1'b0, PIX_CAP}) ? PIX_CAP : bri_sum[CNT_W-1:0];
    upd.abnormal = (abn_sum > {1'b0, ABN_CAP}) ? ABN_CAP : abn_sum[ABN_W-1:0];
  end

  // Counters clear after the last pixel of an image
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
      red_r <= '0;
      bri_r <= '0;
      abn_r <= '0;
      v3_r  <= 1'b0;
    end else begin
      if (take) begin
        if (flg.last) begin
          pix_r <= '0;
          red_r <= '0;
          bri_r <= '0;
          abn_r <= '0;
        end else begin
          pix_r <= upd.pixels;
          red_r <= upd.reddish;
          bri_r <= upd.bright;
          abn_r <= upd.abnormal;
        end
      end
      if (take && flg.last) begin
        v3_r <= 1'b1;
      end else if (snap_ready) begin
        v3_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && flg.last) snap_r <= upd;
  end

  assign snap_valid = v3_r;
  assign snap       = snap_r;

endmodule

// ===== design/scp_verdict.sv =====
// Face verdict from image totals and the result output register.
module scp_verdict (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             snap_valid,
  input  scp_pkg::totals_t snap,
  output logic             snap_ready,
  scp_res_if.source        out_chan
);
  import scp_pkg::*;

  logic             out_v_r;
  logic             face_r;
  logic [ABN_W-1:0] abn_r;
  logic [CNT_W-1:0] bri_r, red_r;

  logic [CNT_W-1:0] half;
  logic [ABN_W:0]   sum_ab;
  logic [21:0]      sum_x5, n_x4;
  logic [19:0]      red_x5, n_x3;
  logic             face;

  assign snap_ready = !out_v_r || out_chan.ready;

  // Verdict compares, constant multiplies as shift-add
  always_comb begin
    half   = snap.pixels >> 1;
    sum_ab = {1'b0, snap.abnormal} + (ABN_W+1)'(snap.bright);
    sum_x5 = (22'(sum_ab) << 2) + 22'(sum_ab);
    n_x4   = 22'(snap.pixels) << 2;
    red_x5 = (20'(snap.reddish) << 2) + 20'(snap.reddish);
    n_x3   = (20'(snap.pixels) << 1) + 20'(snap.pixels);
    face   = !(snap.abnormal > ABN_W'(half))
          && !(snap.bright > half)
          && !(sum_x5 > n_x4)
          && !(red_x5 < n_x3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (snap_ready) begin
      out_v_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      face_r <= face;
      abn_r  <= snap.abnormal;
      bri_r  <= snap.bright;
      red_r  <= snap.reddish;
    end
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.is_face        = face_r;
  assign out_chan.abnormal_total = abn_r;
  assign out_chan.bright_total   = bri_r;
  assign out_chan.reddish_total  = red_r;

endmodule
